FILE: design/dpfm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dpfm_pkg;

   localparam int TIME_W   = 32;
   localparam int COUNT_W  = 16;
   localparam int AVG_W    = 32;
   localparam int ALPHA_W  = 17;
   localparam int LOCK_W   = 16;
   localparam int MINIV_W  = 16;
   localparam int FREQ_W   = 48;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 17;

   localparam int MUL_A_W  = 32;
   localparam int MUL_B_W  = 17;
   localparam int PROD_W   = MUL_A_W + MUL_B_W;

   localparam int QUO_W     = 42;
   localparam int DIV_CNT_W = $clog2(QUO_W + 1);

   localparam logic [ALPHA_W-1:0] ALPHA_ONE   = ALPHA_W'(65536);
   localparam logic [MUL_B_W-1:0] MS_PER_S    = MUL_B_W'(1000);
   localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};

   localparam logic               ENABLE_RST  = 1'b1;
   localparam logic [ALPHA_W-1:0] ALPHA_RST   = ALPHA_W'(32768);
   localparam logic [LOCK_W-1:0]  LOCKOUT_RST = LOCK_W'(2000);
   localparam logic [MINIV_W-1:0] MINIV_RST   = MINIV_W'(50);

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA   = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_LOCKOUT = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_MINIV   = CSR_IDX_W'(3);

   localparam logic MODE_SAMPLE = 1'b0;
   localparam logic MODE_READ   = 1'b1;

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_MIX_NEW = 6'b000010,
      ST_MIX_OLD = 6'b000100,
      ST_SCALE   = 6'b001000,
      ST_DIV     = 6'b010000,
      ST_RESULT  = 6'b100000
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

FILE: design/dpfm_div.sv
`timescale 1ns / 1ps
`default_nettype none

module dpfm_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [dpfm_pkg::QUO_W-1:0]    dividend,
   input  wire logic [dpfm_pkg::TIME_W-1:0]   divisor,
   output dpfm_pkg::div_status_type           status,
   output logic      [dpfm_pkg::QUO_W-1:0]    quotient
);
   import dpfm_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [TIME_W-1:0]    rem_ff, rem_in;
   logic [QUO_W-1:0]     quo_ff, quo_in;
   logic [TIME_W-1:0]    div_ff, div_in;
   logic [TIME_W:0]      trial;
   logic [TIME_W:0]      diff;

   // One quotient bit per cycle; the dividend shifts out of quo_ff as quotient bits shift in.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      trial   = {rem_ff, quo_ff[QUO_W-1]};
      diff    = trial - {1'b0, div_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(QUO_W);
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
      end else if (busy_ff) begin
         if (!diff[TIME_W]) begin
            rem_in = diff[TIME_W-1:0];
            quo_in = {quo_ff[QUO_W-2:0], 1'b1};
         end else begin
            rem_in = trial[TIME_W-1:0];
            quo_in = {quo_ff[QUO_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

`default_nettype wire

FILE: design/debounced_pulse_frequency_meter_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Debounced pulse frequency meter. A sample transfer (mode 0) carries the pin level and a
// microsecond time and gives no result. A level change counts only if lockout_us has passed
// since the last counted change, and the count saturates at 65535. A read transfer (mode 1)
// carries a millisecond time and always gives one result. When the interval since the previous
// read exceeds min_interval_ms and the sensor is enabled, the block updates the smoothed count
// with one shared 32 x 17 multiplier in states MIX_NEW, MIX_OLD and SCALE, then divides by the
// interval in a restoring divider that makes one quotient bit per cycle, 42 bits in all. A read
// that does not report goes straight to the result state. Sample transfers proceed while one
// result waits for the consumer; a second result stalls the block until the first is taken.

module debounced_pulse_frequency_meter_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic [dpfm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [dpfm_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_mode,
   input  wire logic                              req_pin_level,
   input  wire logic [dpfm_pkg::TIME_W-1:0]       req_time_value,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_reading_valid,
   output logic      [dpfm_pkg::FREQ_W-1:0]       rsp_frequency_q16,
   output logic      [dpfm_pkg::COUNT_W-1:0]      rsp_raw_count
);
   import dpfm_pkg::*;

   state_type            state_ff, state_in;
   logic                 enable_ff, enable_in;
   logic [ALPHA_W-1:0]   alpha_ff, alpha_in;
   logic [LOCK_W-1:0]    lockout_ff, lockout_in;
   logic [MINIV_W-1:0]   miniv_ff, miniv_in;
   logic                 level_ff, level_in;
   logic [TIME_W-1:0]    last_tr_ff, last_tr_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [TIME_W-1:0]    last_rd_ff, last_rd_in;
   logic [AVG_W-1:0]     avg_ff, avg_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic [TIME_W-1:0]    dt_ff, dt_in;
   logic [COUNT_W-1:0]   cap_ff, cap_in;
   logic [PROD_W-1:0]    acc_ff, acc_in;
   logic                 good_ff, good_in;
   logic [QUO_W-1:0]     freq_ff, freq_in;
   logic                 out_good_ff, out_good_in;
   logic [QUO_W-1:0]     out_freq_ff, out_freq_in;
   logic [COUNT_W-1:0]   out_count_ff, out_count_in;

   logic [ALPHA_W-1:0]   alpha_eff;
   logic [MUL_B_W-1:0]   alpha_rest;
   logic [MUL_A_W-1:0]   mul_a;
   logic [MUL_B_W-1:0]   mul_b;
   logic [PROD_W-1:0]    prod;
   logic [AVG_W-1:0]     new_avg;
   logic [TIME_W-1:0]    since;
   logic [TIME_W-1:0]    dt_now;
   logic                 accept;
   logic                 div_start;
   div_status_type       div_status;
   logic [QUO_W-1:0]     div_quo;

   assign alpha_eff  = (alpha_ff > ALPHA_ONE) ? ALPHA_ONE : alpha_ff;
   assign alpha_rest = ALPHA_ONE - alpha_eff;
   assign new_avg    = acc_ff[AVG_W+15:16];
   assign since      = req_time_value - last_tr_ff;
   assign dt_now     = req_time_value - last_rd_ff;
   assign req_ready  = (state_ff == ST_IDLE);
   assign accept     = req_valid && req_ready;
   assign div_start  = (state_ff == ST_SCALE);

   // The shared multiplier: new count by alpha, old average by one minus alpha, then the
   // updated average by one thousand.
   always_comb begin
      case (state_ff)
         ST_MIX_NEW: begin
            mul_a = MUL_A_W'(cap_ff);
            mul_b = alpha_eff;
         end
         ST_MIX_OLD: begin
            mul_a = avg_ff;
            mul_b = alpha_rest;
         end
         ST_SCALE: begin
            mul_a = new_avg;
            mul_b = MS_PER_S;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod = mul_a * mul_b;

   always_comb begin
      enable_in    = enable_ff;
      alpha_in     = alpha_ff;
      lockout_in   = lockout_ff;
      miniv_in     = miniv_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ENABLE:  enable_in  = csr_wdata[0];
            CSR_ALPHA:   alpha_in   = csr_wdata[ALPHA_W-1:0];
            CSR_LOCKOUT: lockout_in = csr_wdata[LOCK_W-1:0];
            CSR_MINIV:   miniv_in   = csr_wdata[MINIV_W-1:0];
            default:     ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      level_in     = level_ff;
      last_tr_in   = last_tr_ff;
      count_in     = count_ff;
      last_rd_in   = last_rd_ff;
      avg_in       = avg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      dt_in        = dt_ff;
      cap_in       = cap_ff;
      acc_in       = acc_ff;
      good_in      = good_ff;
      freq_in      = freq_ff;
      out_good_in  = out_good_ff;
      out_freq_in  = out_freq_ff;
      out_count_in = out_count_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_mode == MODE_SAMPLE) begin
                  if (req_pin_level != level_ff && since >= TIME_W'(lockout_ff)) begin
                     if (count_ff != COUNT_MAX) begin
                        count_in = count_ff + COUNT_W'(1);
                     end
                     level_in   = req_pin_level;
                     last_tr_in = req_time_value;
                  end
               end else begin
                  last_rd_in = req_time_value;
                  dt_in      = dt_now;
                  cap_in     = count_ff;
                  if (dt_now > TIME_W'(miniv_ff) && enable_ff) begin
                     count_in = '0;
                     good_in  = 1'b1;
                     state_in = ST_MIX_NEW;
                  end else begin
                     good_in  = 1'b0;
                     freq_in  = '0;
                     state_in = ST_RESULT;
                  end
               end
            end
         end
         ST_MIX_NEW: begin
            acc_in   = {prod[PROD_W-17:0], 16'b0};
            state_in = ST_MIX_OLD;
         end
         ST_MIX_OLD: begin
            acc_in   = acc_ff + prod;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            avg_in   = new_avg;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_status.done) begin
               freq_in  = div_quo;
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               out_good_in  = good_ff;
               out_freq_in  = freq_ff;
               out_count_in = cap_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         enable_ff    <= ENABLE_RST;
         alpha_ff     <= ALPHA_RST;
         lockout_ff   <= LOCKOUT_RST;
         miniv_ff     <= MINIV_RST;
         level_ff     <= 1'b0;
         last_tr_ff   <= '0;
         count_ff     <= '0;
         last_rd_ff   <= '0;
         avg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         enable_ff    <= enable_in;
         alpha_ff     <= alpha_in;
         lockout_ff   <= lockout_in;
         miniv_ff     <= miniv_in;
         level_ff     <= level_in;
         last_tr_ff   <= last_tr_in;
         count_ff     <= count_in;
         last_rd_ff   <= last_rd_in;
         avg_ff       <= avg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dt_ff        <= dt_in;
      cap_ff       <= cap_in;
      acc_ff       <= acc_in;
      good_ff      <= good_in;
      freq_ff      <= freq_in;
      out_good_ff  <= out_good_in;
      out_freq_ff  <= out_freq_in;
      out_count_ff <= out_count_in;
   end

   dpfm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod[QUO_W-1:0]),
      .divisor  (dt_ff),
      .status   (div_status),
      .quotient (div_quo)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_reading_valid = out_good_ff;
   assign rsp_frequency_q16 = FREQ_W'(out_freq_ff);
   assign rsp_raw_count     = out_count_ff;

endmodule

`default_nettype wire

FILE: sim/debounced_pulse_frequency_meter_checker.sv
`timescale 1ns / 1ps

module debounced_pulse_frequency_meter_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [dpfm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dpfm_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic                            req_mode,
   input  logic                            req_pin_level,
   input  logic [dpfm_pkg::TIME_W-1:0]     req_time_value,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic                            rsp_reading_valid,
   input  logic [dpfm_pkg::FREQ_W-1:0]     rsp_frequency_q16,
   input  logic [dpfm_pkg::COUNT_W-1:0]    rsp_raw_count,
   output int                              failures,
   output int                              pending
);
   import dpfm_pkg::*;

   localparam int MAX_PRINTED = 100;
   localparam logic [63:0] FREQ_LIMIT = {{(64 - FREQ_W){1'b0}}, {FREQ_W{1'b1}}};

   typedef struct packed {
      logic               reading_valid;
      logic [FREQ_W-1:0]  frequency_q16;
      logic [COUNT_W-1:0] raw_count;
   } reading_type;

   logic               enabled;
   logic [ALPHA_W-1:0] alpha;
   logic [LOCK_W-1:0]  lockout;
   logic [MINIV_W-1:0] min_iv;

   logic               level_q;
   logic [TIME_W-1:0]  last_edge_us;
   logic [COUNT_W-1:0] edge_count;
   logic [TIME_W-1:0]  last_read_ms;
   logic [AVG_W-1:0]   avg_q16;

   reading_type readings_due[$];
   int fail_count = 0;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (fail_count < MAX_PRINTED) begin
         $display("%0t: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
      end
      fail_count++;
   endtask

   always @(posedge clock) begin
      logic [TIME_W-1:0]  span;
      logic [ALPHA_W-1:0] weight;
      logic [63:0]        mix;
      logic [63:0]        quotient;
      reading_type        want;
      reading_type        got;
      if (reset) begin
         enabled      = ENABLE_RST;
         alpha        = ALPHA_RST;
         lockout      = LOCKOUT_RST;
         min_iv       = MINIV_RST;
         level_q      = 1'b0;
         last_edge_us = '0;
         edge_count   = '0;
         last_read_ms = '0;
         avg_q16      = '0;
         readings_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_ENABLE:  enabled = csr_wdata[0];
               CSR_ALPHA:   alpha   = csr_wdata[ALPHA_W-1:0];
               CSR_LOCKOUT: lockout = csr_wdata[LOCK_W-1:0];
               CSR_MINIV:   min_iv  = csr_wdata[MINIV_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            if (req_mode == MODE_SAMPLE) begin
               if (req_pin_level != level_q) begin
                  span = req_time_value - last_edge_us;
                  if (span >= TIME_W'(lockout)) begin
                     if (edge_count != COUNT_MAX) begin
                        edge_count = edge_count + 1'b1;
                     end
                     level_q      = req_pin_level;
                     last_edge_us = req_time_value;
                  end
               end
            end else begin
               span = req_time_value - last_read_ms;
               last_read_ms = req_time_value;
               want.reading_valid = 1'b0;
               want.frequency_q16 = '0;
               want.raw_count     = edge_count;
               if (span > TIME_W'(min_iv) && enabled) begin
                  weight = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
                  mix = (64'(edge_count) << 16) * 64'(weight)
                      + 64'(avg_q16) * (64'(ALPHA_ONE) - 64'(weight));
                  avg_q16 = mix[AVG_W+15:16];
                  quotient = (64'(avg_q16) * 64'(MS_PER_S)) / 64'(span);
                  want.reading_valid = 1'b1;
                  want.frequency_q16 = (quotient > FREQ_LIMIT) ? {FREQ_W{1'b1}}
                                                               : quotient[FREQ_W-1:0];
                  edge_count = '0;
               end
               readings_due.push_back(want);
            end
         end
         if (rsp_valid && rsp_ready) begin
            got.reading_valid = rsp_reading_valid;
            got.frequency_q16 = rsp_frequency_q16;
            got.raw_count     = rsp_raw_count;
            if (readings_due.size() == 0) begin
               report_mismatch("result transfer with no reading due",
                               64'(got.frequency_q16), 64'(got.raw_count));
            end else begin
               want = readings_due.pop_front();
               if (got.reading_valid != want.reading_valid) begin
                  report_mismatch("reading_valid", 64'(got.reading_valid),
                                  64'(want.reading_valid));
               end
               if (got.frequency_q16 != want.frequency_q16) begin
                  report_mismatch("frequency_q16", 64'(got.frequency_q16),
                                  64'(want.frequency_q16));
               end
               if (got.raw_count != want.raw_count) begin
                  report_mismatch("raw_count", 64'(got.raw_count), 64'(want.raw_count));
               end
            end
         end
      end
      failures <= fail_count;
      pending  <= readings_due.size();
   end

endmodule

FILE: sim/debounced_pulse_frequency_meter_unit_test.sv
`timescale 1ns / 1ps

module debounced_pulse_frequency_meter_unit_test;
   import dpfm_pkg::*;

   localparam int RESET_CYCLES   = 8;
   localparam int DRAIN_CYCLES   = 60;
   localparam int HOLD_CYCLES    = 2000;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int PHASE_ITEMS    = 210;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_mode = MODE_SAMPLE;
   logic                  req_pin_level = 1'b0;
   logic [TIME_W-1:0]     req_time_value = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_reading_valid;
   logic [FREQ_W-1:0]     rsp_frequency_q16;
   logic [COUNT_W-1:0]    rsp_raw_count;

   int failures;
   int pending;

   int req_idle_pct = 35;
   int rsp_idle_pct = 71;
   int stall_requests = 0;
   int stall_served = 0;
   int stall_left = 0;
   int quiet_cycles = 0;

   logic [TIME_W-1:0]  us_now = '0;
   logic [TIME_W-1:0]  ms_now = '0;
   logic               level_now = 1'b0;
   logic [LOCK_W-1:0]  cur_lockout = LOCKOUT_RST;
   logic [MINIV_W-1:0] cur_miniv = MINIV_RST;

   debounced_pulse_frequency_meter_unit dut (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_pin_level     (req_pin_level),
      .req_time_value    (req_time_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_reading_valid (rsp_reading_valid),
      .rsp_frequency_q16 (rsp_frequency_q16),
      .rsp_raw_count     (rsp_raw_count)
   );

   debounced_pulse_frequency_meter_checker reading_checker (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_pin_level     (req_pin_level),
      .req_time_value    (req_time_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_reading_valid (rsp_reading_valid),
      .rsp_frequency_q16 (rsp_frequency_q16),
      .rsp_raw_count     (rsp_raw_count),
      .failures          (failures),
      .pending           (pending)
   );

   always #5 clock = ~clock;

   // A requested hold-off keeps the result side stalled long enough for the block to back up.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left = stall_left - 1;
      end else if (stall_served != stall_requests) begin
         stall_served = stall_requests;
         stall_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("debounced_pulse_frequency_meter_unit_test: FAIL");
            $finish;
         end
      end
   end

   task automatic send_item(input logic mode, input logic level, input logic [TIME_W-1:0] t);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_pin_level  <= level;
      req_time_value <= t;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic apply_setting(input logic en, input logic [ALPHA_W-1:0] weight,
                                input logic [LOCK_W-1:0] lockout,
                                input logic [MINIV_W-1:0] min_iv);
      write_reg(CSR_ENABLE, CSR_DATA_W'({$urandom, en}));
      write_reg(CSR_ALPHA, CSR_DATA_W'(weight));
      write_reg(CSR_LOCKOUT, {1'($urandom), lockout});
      write_reg(CSR_MINIV, {1'($urandom), min_iv});
      write_reg(CSR_IDX_W'($urandom_range(2 ** CSR_IDX_W - 1, CSR_MINIV + 1)),
                CSR_DATA_W'($urandom));
      cur_lockout = lockout;
      cur_miniv = min_iv;
   endtask

   task automatic run_phase(input logic en, input logic [ALPHA_W-1:0] weight,
                            input logic [LOCK_W-1:0] lockout,
                            input logic [MINIV_W-1:0] min_iv,
                            input int req_pct, input int rsp_pct, input logic hold);
      int kind;
      logic [TIME_W-1:0] step;
      wait_idle();
      req_idle_pct = req_pct;
      rsp_idle_pct = rsp_pct;
      apply_setting(en, weight, lockout, min_iv);
      us_now = $urandom;
      ms_now = $urandom;
      if (hold) begin
         stall_requests = stall_requests + 1;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
         kind = $urandom_range(99);
         if (kind < 8) begin
            send_item(1'($urandom), 1'($urandom), $urandom);
         end else if (kind < 25) begin
            case ($urandom_range(3))
               0: step = TIME_W'(cur_miniv);
               1: step = TIME_W'(cur_miniv) + 1;
               2: step = $urandom;
               default: step = $urandom_range(2 * cur_miniv + 2);
            endcase
            ms_now = ms_now + step;
            send_item(MODE_READ, 1'($urandom), ms_now);
         end else begin
            case ($urandom_range(4))
               0: step = TIME_W'(cur_lockout);
               1: step = TIME_W'(cur_lockout) - 1;
               default: step = $urandom_range(2 * cur_lockout + 16);
            endcase
            us_now = us_now + step;
            if ($urandom_range(99) < 75) begin
               level_now = ~level_now;
            end
            send_item(MODE_SAMPLE, level_now, us_now);
         end
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_item(MODE_SAMPLE, 1'b1, 32'd0);
      send_item(MODE_SAMPLE, 1'b1, 32'd2000);
      send_item(MODE_SAMPLE, 1'b1, 32'd3000);
      send_item(MODE_SAMPLE, 1'b0, 32'd3999);
      send_item(MODE_SAMPLE, 1'b0, 32'hFFFF_FFFF);
      send_item(MODE_READ, 1'b0, 32'd50);
      send_item(MODE_READ, 1'b1, 32'd101);
      send_item(MODE_SAMPLE, 1'b1, 32'h0000_07CF);
      send_item(MODE_READ, 1'b0, 32'hFFFF_FFFF);
      send_item(MODE_READ, 1'b1, 32'd0);
      wait_idle();
      apply_setting(1'b0, ALPHA_ONE, 16'd0, 16'd0);
      send_item(MODE_SAMPLE, 1'b0, 32'd5);
      send_item(MODE_READ, 1'b1, 32'd1);
      wait_idle();
      apply_setting(1'b1, 17'h1FFFF, 16'hFFFF, 16'hFFFF);
      send_item(MODE_READ, 1'b0, 32'd65536);
      send_item(MODE_READ, 1'b0, 32'd131072);
      send_item(MODE_SAMPLE, 1'b1, 32'd65539);
      send_item(MODE_SAMPLE, 1'b1, 32'd65540);
      send_item(MODE_READ, 1'b1, 32'd0);
      wait_idle();
      apply_setting(1'b1, 17'd0, 16'd1, 16'd0);
      send_item(MODE_SAMPLE, 1'b0, 32'd100);
      send_item(MODE_READ, 1'b0, 32'd7);

      run_phase(1'b1, ALPHA_RST, LOCKOUT_RST, MINIV_RST, 35, 71, 1'b0);
      run_phase(1'b1, ALPHA_ONE, 16'd0, 16'd0, 35, 71, 1'b0);
      run_phase(1'b1, 17'd0, 16'hFFFF, 16'hFFFF, 35, 71, 1'b0);
      run_phase(1'b0, 17'd20000, 16'd500, 16'd10, 71, 35, 1'b0);
      run_phase(1'b1, 17'h1FFFF, 16'd100, 16'd5, 71, 35, 1'b0);
      run_phase(1'b1, 17'd1, 16'd3000, 16'd200, 71, 35, 1'b0);
      run_phase(1'b1, 17'd49152, 16'd1000, 16'd20, 0, 0, 1'b1);
      run_phase(1'b1, 17'd65537, 16'd50, 16'd1, 0, 0, 1'b0);
      run_phase(1'b1, 17'd12345, 16'd2500, 16'd100, 0, 0, 1'b0);

      wait_idle();
      if (failures == 0 && pending == 0) begin
         $display("debounced_pulse_frequency_meter_unit_test: PASS");
      end else begin
         $display("debounced_pulse_frequency_meter_unit_test: FAIL");
      end
      $finish;
   end

endmodule

FILE: filelist.f
design/dpfm_pkg.sv
design/dpfm_div.sv
design/debounced_pulse_frequency_meter_unit.sv
sim/debounced_pulse_frequency_meter_checker.sv
sim/debounced_pulse_frequency_meter_unit_test.sv
